// ===== hw/rtl/gbn_pkg.sv =====
// ---------------------------------------------------------------------------
// gbn_pkg
// shared types and constants for the go-back-n sender window control
// ---------------------------------------------------------------------------
package gbn_pkg;

  localparam int SEQ_BITS   = 16;
  localparam int STATE_BITS = SEQ_BITS + 1;
  localparam int ADDR_BITS  = 3;

  typedef logic [STATE_BITS-1:0] seq_t;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_t;

  // register select, taken from paddr[2]
  localparam logic REG_TOTAL_FRAMES = 1'b0;
  localparam logic REG_WIN_SIZE     = 1'b1;

  localparam logic [15:0] TOTAL_FRAMES_RESET = 16'd10;
  localparam logic [4:0]  WIN_SIZE_RESET     = 5'd4;

  // one run of sends handed from the front to the back
  typedef struct packed {
    logic sends;
    seq_t first_seq;
    seq_t last_seq;
    logic resend;
    logic done;
  } gbn_job_t;

endpackage

// ===== hw/rtl/gbn_front.sv =====
// ---------------------------------------------------------------------------
// gbn_front
// decodes each request, updates window_base and next_to_send, and works out
// the range of frames the request sends
// ---------------------------------------------------------------------------
module gbn_front import gbn_pkg::*; #(
  parameter int WINDOW_MAX = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     command,
  input  logic [15:0]    ack_number,
  input  logic [15:0]    total_frames,
  input  logic [4:0]     win_size,
  input  logic           job_ready,
  output logic           job_push,
  output gbn_job_t       job
);

  localparam int WW = $clog2(WINDOW_MAX + 1);

  seq_t           window_base;
  seq_t           next_to_send;
  seq_t           base_new;
  seq_t           next_start;
  seq_t           limit;
  seq_t           total_ext;
  seq_t           last_seq;
  logic [WW-1:0]  win_eff;
  logic           do_send;
  logic           resend;
  logic           ack_ok;

  assign total_ext = {1'b0, total_frames};
  assign ack_ok    = (window_base <= total_ext) && ({1'b0, ack_number} == window_base);

  always_comb begin
    if (win_size == 5'd0) begin
      win_eff = WW'(1);
    end else if (int'(win_size) > WINDOW_MAX) begin
      win_eff = WW'(WINDOW_MAX);
    end else begin
      win_eff = WW'(win_size);
    end
  end

  always_comb begin
    base_new   = window_base;
    next_start = next_to_send;
    do_send    = 1'b0;
    resend     = 1'b0;
    case (command)
      CMD_START: begin
        base_new   = STATE_BITS'(1);
        next_start = STATE_BITS'(1);
        do_send    = 1'b1;
      end
      CMD_ACK: begin
        if (ack_ok) begin
          base_new   = window_base + STATE_BITS'(1);
          next_start = (next_to_send < base_new) ? base_new : next_to_send;
          do_send    = 1'b1;
        end
      end
      CMD_TIMEOUT: begin
        next_start = window_base;
        do_send    = 1'b1;
        resend     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // last frame the window and the frame count allow
  assign limit    = base_new + STATE_BITS'(win_eff);
  assign last_seq = (limit <= total_ext) ? (limit - STATE_BITS'(1)) : total_ext;

  assign job_push       = in_valid && job_ready;
  assign job.sends      = do_send && (next_start <= last_seq);
  assign job.first_seq  = next_start;
  assign job.last_seq   = last_seq;
  assign job.resend     = resend;
  assign job.done       = base_new > total_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base  <= STATE_BITS'(1);
      next_to_send <= STATE_BITS'(1);
    end else if (job_push) begin
      window_base <= base_new;
      if (job.sends) begin
        next_to_send <= last_seq + STATE_BITS'(1);
      end else if (do_send) begin
        next_to_send <= next_start;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_next_not_behind: assert property (@(posedge clk) disable iff (rst)
    next_to_send >= window_base)
    else $error("next_to_send fell behind window_base");

  a_run_in_window: assert property (@(posedge clk) disable iff (rst)
    (job_push && job.sends) |-> (job.first_seq >= base_new) &&
      (job.last_seq - job.first_seq < STATE_BITS'(WINDOW_MAX)))
    else $error("run leaves the window");

  a_state_moves: assert property (@(posedge clk) disable iff (rst)
    (job_push && job.sends) |=> next_to_send == $past(job.last_seq) + STATE_BITS'(1))
    else $error("next_to_send not past the run");
`endif

endmodule

// ===== hw/rtl/gbn_queue.sv =====
// ---------------------------------------------------------------------------
// gbn_queue
// two-entry queue of runs between the front and the back
// ---------------------------------------------------------------------------
module gbn_queue import gbn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  gbn_job_t  push_job,
  output logic      push_ready,
  input  logic      pop,
  output logic      pop_valid,
  output gbn_job_t  pop_job
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  gbn_job_t        entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     fill;

  assign push_ready = fill != (PW+1)'(DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_job    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + (PW+1)'(1);
        2'b01:   fill <= fill - (PW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ready)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("pop from empty queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (PW+1)'(DEPTH))
    else $error("queue fill out of range");
`endif

endmodule

// ===== hw/rtl/gbn_back.sv =====
// ---------------------------------------------------------------------------
// gbn_back
// walks each run one frame per cycle into the output register, unless out_ready stalls it
// ---------------------------------------------------------------------------
module gbn_back import gbn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  gbn_job_t             job,
  output logic                 job_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_frame_valid,
  output logic [SEQ_BITS-1:0]  out_seq,
  output logic                 out_resend,
  output logic                 out_last,
  output logic                 out_done
);

  logic  active;
  seq_t  cur_seq;
  seq_t  run_last;
  logic  run_resend;
  logic  run_done;
  logic  advance;

  assign advance = !out_valid || out_ready;
  assign job_pop = advance && !active && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      active    <= 1'b0;
    end else if (advance) begin
      if (active) begin
        out_valid <= 1'b1;
        active    <= cur_seq != run_last;
      end else if (job_valid) begin
        out_valid <= 1'b1;
        active    <= job.sends && (job.first_seq != job.last_seq);
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (active) begin
        out_frame_valid <= 1'b1;
        out_seq         <= cur_seq[SEQ_BITS-1:0];
        out_resend      <= run_resend;
        out_last        <= cur_seq == run_last;
        out_done        <= run_done;
        cur_seq         <= cur_seq + STATE_BITS'(1);
      end else if (job_valid) begin
        run_last   <= job.last_seq;
        run_resend <= job.resend;
        run_done   <= job.done;
        cur_seq    <= job.first_seq + STATE_BITS'(1);
        out_done   <= job.done;
        if (job.sends) begin
          out_frame_valid <= 1'b1;
          out_seq         <= job.first_seq[SEQ_BITS-1:0];
          out_resend      <= job.resend;
          out_last        <= job.first_seq == job.last_seq;
        end else begin
          // status-only item
          out_frame_valid <= 1'b0;
          out_seq         <= '0;
          out_resend      <= 1'b0;
          out_last        <= 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_frame_valid) |-> out_last && (out_seq == '0) && !out_resend)
    else $error("malformed status item");

  a_active_has_item: assert property (@(posedge clk) disable iff (rst)
    active |-> out_valid && !out_last)
    else $error("run in progress without pending item");

  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> out_valid)
    else $error("popped run produced no item");
`endif

endmodule

// ===== hw/rtl/go_back_n_sender_top.sv =====
// ---------------------------------------------------------------------------
// go_back_n_sender_top
// go-back-n sender window control with a register port
// ---------------------------------------------------------------------------
// channel  dir  tdata                         tuser                   tlast
// s_*      in   [15:0] ack_number             [1:0] command           -
// m_*      out  [15:0] seq_number,            [0] frame_valid,        last_of_run
//               [16] all_acknowledged         [1] is_resend
// apb      in   total_frames @0, win_size @4
//
// a request is decoded and queued when accepted; up to two runs wait in the
// queue. the back emits one result per cycle unless m_tready stalls it: a
// request gives one status item if it sends nothing, else one item per frame,
// at most WINDOW_MAX; the back's single output walker sets the rate.
// rst is synchronous and returns window_base, next_to_send and registers to
// their defaults. either side may stall; the queue decouples them.
// ---------------------------------------------------------------------------
module go_back_n_sender_top import gbn_pkg::*; #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [15:0] ack_number
  input  logic [1:0]            s_tuser,   // [1:0] command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // [15:0] seq_number, [16] all_acknowledged
  output logic [1:0]            m_tuser,   // [0] frame_valid, [1] is_resend
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [15:0]          total_frames;
  logic [4:0]           win_size;
  logic                 job_push;
  logic                 job_ready;
  gbn_job_t             push_job;
  logic                 job_pop;
  logic                 job_valid;
  gbn_job_t             head_job;
  logic                 out_frame_valid;
  logic [SEQ_BITS-1:0]  out_seq;
  logic                 out_resend;
  logic                 out_done;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames <= TOTAL_FRAMES_RESET;
      win_size     <= WIN_SIZE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_TOTAL_FRAMES: total_frames <= pwdata[15:0];
        REG_WIN_SIZE:     win_size     <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TOTAL_FRAMES: prdata = {16'd0, total_frames};
      REG_WIN_SIZE:     prdata = {27'd0, win_size};
      default:          prdata = '0;
    endcase
  end

  assign s_tready = job_ready;

  gbn_front #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .command      (s_tuser),
    .ack_number   (s_tdata),
    .total_frames (total_frames),
    .win_size     (win_size),
    .job_ready    (job_ready),
    .job_push     (job_push),
    .job          (push_job)
  );

  gbn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (push_job),
    .push_ready (job_ready),
    .pop        (job_pop),
    .pop_valid  (job_valid),
    .pop_job    (head_job)
  );

  gbn_back u_back (
    .clk             (clk),
    .rst             (rst),
    .job_valid       (job_valid),
    .job             (head_job),
    .job_pop         (job_pop),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_frame_valid (out_frame_valid),
    .out_seq         (out_seq),
    .out_resend      (out_resend),
    .out_last        (m_tlast),
    .out_done        (out_done)
  );

  assign m_tdata = {7'd0, out_done, out_seq};
  assign m_tuser = {out_resend, out_frame_valid};

endmodule
